// ===== src/gafp_pkg.sv =====
// Shared constants for the grid adjacent free pair counter.
// No dependencies; imported by the top level and the bench.
`default_nettype none
package gafp_pkg;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int CNT_W    = 8;
	localparam int DIM_W    = 9;
	localparam int PAIR_W   = 17;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_ROWS = 1 << ROW_W;
	localparam int MAX_COLS = 1 << COL_W;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int CNT_DEPTH = MAX_ROWS * MAX_COLS;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

	localparam logic [DIM_W-1:0] GRID_RESET = 9'd256;
endpackage
`default_nettype wire

// ===== src/gafp_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module gafp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/grid_adjacent_free_pair_counter.sv =====
// Top level of the grid adjacent free pair counter: sequencer and count memories.
// Depends on gafp_pkg and gafp_ram.
// Load: reads neighbour counts in ST_LD_RD, writes them in ST_LD_WR; no result.
// An out-of-grid load is accepted and dropped. Query: one column or row per cycle
// through replicated count memories, then ST_QFIN; result strobed on done in the
// same cycle that busy falls. Results cannot be stalled.
// Reset: registers default to 256 rows and columns; memories undefined until loaded.
`default_nettype none
module grid_adjacent_free_pair_counter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            req_type,
	input  wire logic [gafp_pkg::ROW_W-1:0]      cell_row,
	input  wire logic [gafp_pkg::COL_W-1:0]      cell_col,
	input  wire logic                            cell_free,
	input  wire logic [gafp_pkg::ROW_W-1:0]      top_row,
	input  wire logic [gafp_pkg::COL_W-1:0]      left_col,
	input  wire logic [gafp_pkg::ROW_W-1:0]      bottom_row,
	input  wire logic [gafp_pkg::COL_W-1:0]      right_col,
	output logic                                 done,
	output logic [gafp_pkg::PAIR_W-1:0]          pair_count,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [gafp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gafp_pkg::DIM_W-1:0]      cfg_data
);
	import gafp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LD_RD = 3'd1;
	localparam logic [2:0] ST_LD_WR = 3'd2;
	localparam logic [2:0] ST_QV    = 3'd3;
	localparam logic [2:0] ST_QH    = 3'd4;
	localparam logic [2:0] ST_QFIN  = 3'd5;

	function automatic logic [ROW_W-1:0] clamp_idx(input logic [ROW_W-1:0] v,
		input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] lim;
		lim = n - DIM_W'(1);
		return ({1'b0, v} >= n) ? lim[ROW_W-1:0] : v;
	endfunction

	logic [2:0]         state_q;
	logic [DIM_W-1:0]   rows_q, cols_q, rows_eff, cols_eff;
	logic [ROW_W-1:0]   r1_q, r2_q, idx_q;
	logic [COL_W-1:0]   c1_q, c2_q;
	logic               free_q, left_q;
	logic [PAIR_W-1:0]  total_q, total_nxt, pair_count_q;
	logic               done_q;
	logic               rd_s1, sel_h_s1;
	logic               accept;

	logic [ADDR_W-1:0]  va_raddr, vb_raddr, ha_raddr, hb_raddr, cnt_waddr;
	logic [CNT_W-1:0]   va_rdata, vb_rdata, ha_rdata, hb_rdata;
	logic [CNT_W-1:0]   v_wdata, h_wdata, diff_a, diff_b, diff;
	logic               prev_rdata, ld_we;

	assign cfg_ready  = 1'b1;
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign pair_count = pair_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= GRID_RESET;
			cols_q <= GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_ROWS: rows_q <= cfg_data;
				REG_GRID_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0)
			rows_eff = DIM_W'(1);
		else if (rows_q > DIM_W'(MAX_ROWS))
			rows_eff = DIM_W'(MAX_ROWS);
		else
			rows_eff = rows_q;
		if (cols_q == '0)
			cols_eff = DIM_W'(1);
		else if (cols_q > DIM_W'(MAX_COLS))
			cols_eff = DIM_W'(MAX_COLS);
		else
			cols_eff = cols_q;
	end

	// read address selection
	always_comb begin
		va_raddr = {r2_q, idx_q};
		ha_raddr = {idx_q, c2_q};
		if (state_q == ST_LD_RD) begin
			va_raddr = {r1_q - ROW_W'(1), c1_q};
			ha_raddr = {r1_q, c1_q - COL_W'(1)};
		end
	end
	assign vb_raddr  = {r1_q, idx_q};
	assign hb_raddr  = {idx_q, c1_q};
	assign cnt_waddr = {r1_q, c1_q};
	assign ld_we     = (state_q == ST_LD_WR);

	assign v_wdata = (r1_q == '0) ? '0 : va_rdata + CNT_W'(prev_rdata & free_q);
	assign h_wdata = (c1_q == '0) ? '0 : ha_rdata + CNT_W'(left_q & free_q);

	// one column or row difference per cycle
	assign diff_a    = sel_h_s1 ? ha_rdata : va_rdata;
	assign diff_b    = sel_h_s1 ? hb_rdata : vb_rdata;
	assign diff      = (rd_s1 && diff_a > diff_b) ? diff_a - diff_b : '0;
	assign total_nxt = total_q + PAIR_W'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			left_q   <= 1'b0;
			done_q   <= 1'b0;
			rd_s1    <= 1'b0;
			sel_h_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rd_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_QUERY) begin
							r1_q    <= clamp_idx(top_row, rows_eff);
							r2_q    <= clamp_idx(bottom_row, rows_eff);
							c1_q    <= clamp_idx(left_col, cols_eff);
							c2_q    <= clamp_idx(right_col, cols_eff);
							idx_q   <= clamp_idx(left_col, cols_eff);
							total_q <= '0;
							state_q <= ST_QV;
						end else if ({1'b0, cell_row} < rows_eff &&
							{1'b0, cell_col} < cols_eff) begin
							r1_q    <= cell_row;
							c1_q    <= cell_col;
							free_q  <= cell_free;
							state_q <= ST_LD_RD;
						end
					end
				end
				ST_LD_RD: state_q <= ST_LD_WR;
				ST_LD_WR: begin
					left_q  <= free_q;
					state_q <= ST_IDLE;
				end
				ST_QV: begin
					total_q <= total_nxt;
					if (idx_q <= c2_q) begin
						rd_s1    <= 1'b1;
						sel_h_s1 <= 1'b0;
					end
					if (idx_q >= c2_q) begin
						idx_q   <= r1_q;
						state_q <= ST_QH;
					end else begin
						idx_q <= idx_q + ROW_W'(1);
					end
				end
				ST_QH: begin
					total_q <= total_nxt;
					if (idx_q <= r2_q) begin
						rd_s1    <= 1'b1;
						sel_h_s1 <= 1'b1;
					end
					if (idx_q >= r2_q) begin
						state_q <= ST_QFIN;
					end else begin
						idx_q <= idx_q + ROW_W'(1);
					end
				end
				ST_QFIN: begin
					pair_count_q <= total_nxt;
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// vertical counts, two copies for two reads per cycle
	gafp_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH)) u_vcnt_a (
		.clk(clk), .we(ld_we), .waddr(cnt_waddr), .wdata(v_wdata),
		.raddr(va_raddr), .rdata(va_rdata)
	);
	gafp_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH)) u_vcnt_b (
		.clk(clk), .we(ld_we), .waddr(cnt_waddr), .wdata(v_wdata),
		.raddr(vb_raddr), .rdata(vb_rdata)
	);
	// horizontal counts
	gafp_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH)) u_hcnt_a (
		.clk(clk), .we(ld_we), .waddr(cnt_waddr), .wdata(h_wdata),
		.raddr(ha_raddr), .rdata(ha_rdata)
	);
	gafp_ram #(.WIDTH(CNT_W), .DEPTH(CNT_DEPTH)) u_hcnt_b (
		.clk(clk), .we(ld_we), .waddr(cnt_waddr), .wdata(h_wdata),
		.raddr(hb_raddr), .rdata(hb_rdata)
	);
	// last free bit loaded in each column
	gafp_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_prev (
		.clk(clk), .we(ld_we), .waddr(c1_q), .wdata(free_q),
		.raddr(c1_q), .rdata(prev_rdata)
	);
endmodule
`default_nettype wire

// ===== bench/grid_adjacent_free_pair_counter_tb.sv =====
// Self-checking bench for grid_adjacent_free_pair_counter: cell loads, rectangle
// queries and register writes against an in-bench pair-count predictor.
// Depends on gafp_pkg and the RTL top level only.
module grid_adjacent_free_pair_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gafp_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 11;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 200;
	localparam int unsigned PAIR_LIMIT = (1 << PAIR_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic             req_type;
		logic [ROW_W-1:0] cell_row;
		logic [COL_W-1:0] cell_col;
		logic             cell_free;
		logic [ROW_W-1:0] top_row;
		logic [COL_W-1:0] left_col;
		logic [ROW_W-1:0] bottom_row;
		logic [COL_W-1:0] right_col;
	} grid_req_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 req_type   = REQ_LOAD;
	logic [ROW_W-1:0]     cell_row   = '0;
	logic [COL_W-1:0]     cell_col   = '0;
	logic                 cell_free  = 1'b0;
	logic [ROW_W-1:0]     top_row    = '0;
	logic [COL_W-1:0]     left_col   = '0;
	logic [ROW_W-1:0]     bottom_row = '0;
	logic [COL_W-1:0]     right_col  = '0;
	logic                 cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_GRID_ROWS;
	logic [DIM_W-1:0]     cfg_data   = '0;
	logic                 busy;
	logic                 done;
	logic [PAIR_W-1:0]    pair_count;
	logic                 cfg_ready;

	// predictor state
	logic [CNT_W-1:0]  vert_run [CNT_DEPTH];
	logic [CNT_W-1:0]  horz_run [CNT_DEPTH];
	logic              col_last_free [MAX_COLS];
	logic              prev_free = 1'b0;
	logic [DIM_W-1:0]  rows_reg  = GRID_RESET;
	logic [DIM_W-1:0]  cols_reg  = GRID_RESET;
	logic [PAIR_W-1:0] pending_counts [$];

	int errors       = 0;
	int loads_sent   = 0;
	int queries_sent = 0;
	int cfg_writes   = 0;
	int send_gap_pct = 18;
	int idle_run     = 0;

	grid_adjacent_free_pair_counter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_free  (cell_free),
		.top_row    (top_row),
		.left_col   (left_col),
		.bottom_row (bottom_row),
		.right_col  (right_col),
		.done       (done),
		.pair_count (pair_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int unsigned active_dim(logic [DIM_W-1:0] v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic int unsigned clip(int unsigned v, int unsigned n);
		return (v >= n) ? n - 1 : v;
	endfunction

	function automatic void update_grid(grid_req_t w);
		int unsigned rows, cols, idx;
		rows = active_dim(rows_reg, MAX_ROWS);
		cols = active_dim(cols_reg, MAX_COLS);
		if (w.cell_row >= rows || w.cell_col >= cols)
			return;
		idx = w.cell_row * MAX_COLS + w.cell_col;
		if (w.cell_row == 0)
			vert_run[idx] = '0;
		else
			vert_run[idx] = vert_run[idx - MAX_COLS] + (col_last_free[w.cell_col] & w.cell_free);
		if (w.cell_col == 0)
			horz_run[idx] = '0;
		else
			horz_run[idx] = horz_run[idx - 1] + (prev_free & w.cell_free);
		col_last_free[w.cell_col] = w.cell_free;
		prev_free = w.cell_free;
	endfunction

	function automatic logic [PAIR_W-1:0] count_pairs(grid_req_t w);
		int unsigned rows, cols, r1, c1, r2, c2, total, a, b, i;
		rows  = active_dim(rows_reg, MAX_ROWS);
		cols  = active_dim(cols_reg, MAX_COLS);
		r1    = clip(w.top_row, rows);
		c1    = clip(w.left_col, cols);
		r2    = clip(w.bottom_row, rows);
		c2    = clip(w.right_col, cols);
		total = 0;
		for (i = c1; i <= c2; i++) begin
			a = vert_run[r2 * MAX_COLS + i];
			b = vert_run[r1 * MAX_COLS + i];
			if (a > b)
				total += a - b;
		end
		for (i = r1; i <= r2; i++) begin
			a = horz_run[i * MAX_COLS + c2];
			b = horz_run[i * MAX_COLS + c1];
			if (a > b)
				total += a - b;
		end
		if (total > PAIR_LIMIT)
			total = PAIR_LIMIT;
		return total[PAIR_W-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// one word per call; start is left high so back-to-back words need no toggle
	task automatic send_word(grid_req_t w);
		int gap;
		if ($urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(5, 1);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		req_type   <= w.req_type;
		cell_row   <= w.cell_row;
		cell_col   <= w.cell_col;
		cell_free  <= w.cell_free;
		top_row    <= w.top_row;
		left_col   <= w.left_col;
		bottom_row <= w.bottom_row;
		right_col  <= w.right_col;
		do @(posedge clk); while (busy !== 1'b0);
		if (w.req_type == REQ_QUERY) begin
			pending_counts.push_back(count_pairs(w));
			queries_sent++;
		end else begin
			update_grid(w);
			loads_sent++;
		end
	endtask

	task automatic load_cell(int unsigned r, int unsigned c, logic f);
		grid_req_t w;
		w           = grid_req_t'({$urandom, $urandom});
		w.req_type  = REQ_LOAD;
		w.cell_row  = r[ROW_W-1:0];
		w.cell_col  = c[COL_W-1:0];
		w.cell_free = f;
		send_word(w);
	endtask

	task automatic ask_rect(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
		grid_req_t w;
		w            = grid_req_t'({$urandom, $urandom});
		w.req_type   = REQ_QUERY;
		w.top_row    = t[ROW_W-1:0];
		w.left_col   = l[COL_W-1:0];
		w.bottom_row = b[ROW_W-1:0];
		w.right_col  = r[COL_W-1:0];
		send_word(w);
	endtask

	// stop sending and let every pending count come back, then let a load finish
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_GRID_ROWS)
			rows_reg = data;
		else if (idx == REG_GRID_COLS)
			cols_reg = data;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// row-major fill of the whole grid in use
	task automatic load_grid(int free_pct);
		int unsigned rows, cols, r, c;
		rows = active_dim(rows_reg, MAX_ROWS);
		cols = active_dim(cols_reg, MAX_COLS);
		for (r = 0; r < rows; r++)
			for (c = 0; c < cols; c++)
				load_cell(r, c, $urandom_range(99) < free_pct);
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return 9'd0;
			1: return 9'd1;
			default: return 9'($urandom_range(8, 2));
		endcase
	endfunction

	task automatic test_reset_defaults();
		load_cell(0, 0, 1'b1);
		load_cell(0, 1, 1'b1);
		ask_rect(0, 0, 0, 1);
		ask_rect(0, 0, 0, 0);
		ask_rect(0, 1, 0, 0);
		drain();
	endtask

	task automatic test_directed_small();
		logic [11:0] pattern;
		int unsigned r, c;
		pattern = 12'b0111_1111_1101;
		write_reg(REG_GRID_ROWS, 9'd3);
		write_reg(REG_GRID_COLS, 9'd4);
		for (r = 0; r < 3; r++)
			for (c = 0; c < 4; c++)
				load_cell(r, c, pattern[r * 4 + (3 - c)]);
		ask_rect(0, 0, 2, 3);
		ask_rect(1, 1, 1, 1);
		ask_rect(2, 0, 0, 3);
		ask_rect(0, 3, 2, 0);
		ask_rect(2, 3, 0, 0);
		ask_rect(255, 255, 255, 255);
		ask_rect(0, 0, 255, 255);
		load_cell(3, 0, 1'b1);
		load_cell(0, 255, 1'b1);
		load_cell(1, 2, 1'b0);
		ask_rect(0, 0, 2, 3);
		drain();
	endtask

	task automatic test_register_extremes();
		int unsigned c;
		// over-range rows act as the maximum, zero columns as one
		write_reg(REG_GRID_ROWS, 9'h1FF);
		write_reg(REG_GRID_COLS, 9'd0);
		load_grid(90);
		ask_rect(0, 0, 255, 255);
		ask_rect($urandom_range(127), 0, $urandom_range(255, 128), 0);
		ask_rect(255, 0, 0, 0);
		// zero rows act as one, over-range columns as the maximum
		write_reg(REG_GRID_ROWS, 9'd0);
		write_reg(REG_GRID_COLS, 9'h1FF);
		for (c = 0; c < 16; c++)
			load_cell(0, c, $urandom_range(99) < 90);
		ask_rect(255, 0, 0, 15);
		ask_rect(0, 12, 255, 3);
		write_reg(REG_SPARE, 9'h155);
		ask_rect(0, 0, 255, 15);
		drain();
	endtask

	task automatic test_random_traffic();
		int real_items, op, kind;
		int unsigned rows, cols, r, c, a, b, x, y;
		real_items = 0;
		while (real_items < RANDOM_ITEMS) begin
			if (real_items < RANDOM_ITEMS / 3)
				send_gap_pct = 18;
			else if (real_items < 2 * RANDOM_ITEMS / 3)
				send_gap_pct = 48;
			else
				send_gap_pct = 0;
			write_reg(REG_GRID_ROWS, pick_dim());
			write_reg(REG_GRID_COLS, pick_dim());
			rows = active_dim(rows_reg, MAX_ROWS);
			cols = active_dim(cols_reg, MAX_COLS);
			load_grid($urandom_range(95, 40));
			real_items += rows * cols;
			repeat ($urandom_range(16, 6)) begin
				op = $urandom_range(99);
				if (op < 8) begin
					r = $urandom_range(255);
					c = $urandom_range(255);
					if ($urandom_range(1))
						r = $urandom_range(255, rows);
					else
						c = $urandom_range(255, cols);
					load_cell(r, c, $urandom_range(1));
				end else if (op < 18) begin
					load_cell($urandom_range(rows - 1), $urandom_range(cols - 1), $urandom_range(1));
					real_items++;
				end else begin
					kind = $urandom_range(99);
					a = $urandom_range(rows - 1);
					b = $urandom_range(rows - 1);
					x = $urandom_range(cols - 1);
					y = $urandom_range(cols - 1);
					if (kind < 65)
						ask_rect(a < b ? a : b, x < y ? x : y, a < b ? b : a, x < y ? y : x);
					else if (kind < 80)
						ask_rect($urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(255));
					else if (kind < 90)
						ask_rect(a < b ? b : a, x, a < b ? a : b, y);
					else
						ask_rect(a, x < y ? y : x, b, x < y ? x : y);
					real_items++;
				end
				if ($urandom_range(19) == 0)
					drain();
			end
		end
	endtask

	always @(posedge clk) begin
		logic [PAIR_W-1:0] want;
		if (arst_n && done === 1'b1) begin
			if (pending_counts.size() == 0) begin
				report_mismatch($sformatf("pair_count %0d with no query pending", pair_count));
			end else begin
				want = pending_counts.pop_front();
				if (pair_count !== want)
					report_mismatch($sformatf("pair_count got %0d, want %0d", pair_count, want));
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_small();
		test_register_extremes();
		test_random_traffic();
		drain();
		$display("Run covered %0d cell loads and %0d rectangle queries", loads_sent, queries_sent);
		$display("over %0d register writes, grids from 1x1 up to 256 rows or columns", cfg_writes);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== grid_adjacent_free_pair_counter.f =====
src/gafp_pkg.sv
src/gafp_ram.sv
src/grid_adjacent_free_pair_counter.sv
bench/grid_adjacent_free_pair_counter_tb.sv
